// ----- rtl/gdm_pkg.sv -----
// Shared constants, configuration and queue types for the divergence maximum core.
// No dependencies; every other file in rtl/ imports this package.
`default_nettype none

package gdm_pkg;

  // Grid and field geometry.
  localparam int FIELD_W       = 24;
  localparam int MAX_CELLS_Y   = 64;
  localparam int MAX_CELLS_Z   = 64;
  localparam int CELLS_X_LIMIT = 4096;
  localparam int PLANE_SIZE    = MAX_CELLS_Y * MAX_CELLS_Z;
  localparam int STORE_DEPTH   = 2 * PLANE_SIZE;
  localparam int ADDR_W        = $clog2(STORE_DEPTH);
  localparam int IW            = $clog2(CELLS_X_LIMIT);
  localparam int JW            = $clog2(MAX_CELLS_Y);
  localparam int KW            = $clog2(MAX_CELLS_Z);

  // Configuration register widths.
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 32;
  localparam int CX_W      = 13;
  localparam int CY_W      = 7;
  localparam int CZ_W      = 7;
  localparam int H_W       = 32;
  localparam int H_HALF_W  = H_W / 2;

  // Arithmetic widths along the datapath.
  localparam int FRAC_BITS = 16;
  localparam int DIFF_W    = FIELD_W + 1;
  localparam int PROD_W    = DIFF_W + H_HALF_W + 1;
  localparam int SUM_W     = PROD_W + 2;
  localparam int TOT_W     = SUM_W + FRAC_BITS + 1;
  localparam int MAG_W     = TOT_W - FRAC_BITS;
  localparam int RES_W     = 48;
  localparam logic [63:0] RESULT_MAX = 64'h0000_FFFF_FFFF_FFFF;

  // Stream widths, padded to whole bytes.
  localparam int S_DATA_W = ((3 * FIELD_W + 7) / 8) * 8;
  localparam int M_DATA_W = ((RES_W + 7) / 8) * 8;

  // Queue between the front and back.
  localparam int Q_DEPTH = 4;
  localparam int QP_W    = $clog2(Q_DEPTH);
  localparam int QC_W    = $clog2(Q_DEPTH + 1);

  // Register indexes on the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAGNETIC_MODE = 3'd0,
    CFG_CELLS_X       = 3'd1,
    CFG_CELLS_Y       = 3'd2,
    CFG_CELLS_Z       = 3'd3,
    CFG_HALF_INV_X    = 3'd4,
    CFG_HALF_INV_Y    = 3'd5,
    CFG_HALF_INV_Z    = 3'd6
  } cfg_index_t;

  typedef struct packed {
    logic            magnetic_mode;
    logic [CX_W-1:0] cells_x;
    logic [CY_W-1:0] cells_y;
    logic [CZ_W-1:0] cells_z;
    logic [H_W-1:0]  half_inv_spacing_x;
    logic [H_W-1:0]  half_inv_spacing_y;
    logic [H_W-1:0]  half_inv_spacing_z;
  } gdm_cfg_t;

  // Per-cell classification made by the front.
  typedef struct packed {
    logic calc;   // cell closes a centre whose divergence is taken
    logic last;   // final cell of the grid, emits the result
    logic clear;  // grid start, clears maximum and flag first
  } gdm_flags_t;

  typedef struct packed {
    gdm_flags_t        flags;
    logic [DIFF_W-1:0] dx;
    logic [DIFF_W-1:0] dy;
    logic [DIFF_W-1:0] dz;
  } gdm_item_t;

endpackage

`default_nettype wire

// ----- rtl/gdm_front.sv -----
// Front of the divergence core: grid position counters, cell classification and
// the three plane stores. Depends on gdm_pkg; feeds differences into gdm_queue.
`default_nettype none

module gdm_front (
  input  logic                              clk,
  input  logic                              rst,
  input  gdm_pkg::gdm_cfg_t                 cfg,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [gdm_pkg::FIELD_W-1:0]       field_x,
  input  logic [gdm_pkg::FIELD_W-1:0]       field_y,
  input  logic [gdm_pkg::FIELD_W-1:0]       field_z,
  input  logic                              grid_start,
  input  logic [gdm_pkg::QC_W-1:0]          q_count,
  output logic                              push,
  output gdm_pkg::gdm_item_t                push_item
);
  import gdm_pkg::*;

  // Position counters.
  logic [IW-1:0] pos_i, pos_i_next;
  logic [JW-1:0] pos_j, pos_j_next;
  logic [KW-1:0] pos_k, pos_k_next;

  // Clamped counts and their last indexes.
  logic [CX_W-1:0] nx;
  logic [CY_W-1:0] ny;
  logic [CZ_W-1:0] nz;
  logic [IW-1:0]   last_i;
  logic [JW-1:0]   last_j;
  logic [KW-1:0]   last_k;

  logic          accept;
  logic [IW-1:0] p_i;
  logic [JW-1:0] p_j;
  logic [KW-1:0] p_k;
  logic          k_more, j_more, i_more;
  logic          calc, is_last;
  logic [QC_W:0] inflight;

  // Store addresses.
  logic [ADDR_W-1:0] here_addr, row_addr;
  logic [ADDR_W-1:0] y_hi_addr, y_lo_addr, z_hi_addr, z_lo_addr;

  // Plane stores, two planes each, selected by the low bit of i.
  logic [FIELD_W-1:0] x_mem [STORE_DEPTH];
  logic [FIELD_W-1:0] y_mem [STORE_DEPTH];
  logic [FIELD_W-1:0] z_mem [STORE_DEPTH];

  // Stage after the store reads.
  logic                      f1_valid;
  gdm_flags_t                f1_flags;
  logic signed [FIELD_W-1:0] fx_q;
  logic signed [FIELD_W-1:0] x_rd, y_hi_rd, y_lo_rd, z_hi_rd, z_lo_rd;

  // Counts are clamped to the supported grid.
  always_comb begin
    if (cfg.cells_x == '0) begin
      nx = CX_W'(1);
    end else if (cfg.cells_x > CX_W'(CELLS_X_LIMIT)) begin
      nx = CX_W'(CELLS_X_LIMIT);
    end else begin
      nx = cfg.cells_x;
    end
    if (cfg.cells_y == '0) begin
      ny = CY_W'(1);
    end else if (cfg.cells_y > CY_W'(MAX_CELLS_Y)) begin
      ny = CY_W'(MAX_CELLS_Y);
    end else begin
      ny = cfg.cells_y;
    end
    if (cfg.cells_z == '0) begin
      nz = CZ_W'(1);
    end else if (cfg.cells_z > CZ_W'(MAX_CELLS_Z)) begin
      nz = CZ_W'(MAX_CELLS_Z);
    end else begin
      nz = cfg.cells_z;
    end
    last_i = IW'(nx - CX_W'(1));
    last_j = JW'(ny - CY_W'(1));
    last_k = KW'(nz - CZ_W'(1));
  end

  // Room is kept in the queue for the beat in the read stage and the new one.
  assign inflight = (QC_W + 1)'(q_count) + (QC_W + 1)'(f1_valid);
  assign in_ready = (inflight < (QC_W + 1)'(Q_DEPTH));
  assign accept   = in_valid & in_ready;

  // Classification of the current cell and the next position.
  always_comb begin
    p_i = grid_start ? '0 : pos_i;
    p_j = grid_start ? '0 : pos_j;
    p_k = grid_start ? '0 : pos_k;

    k_more  = (p_k < last_k);
    j_more  = (p_j < last_j);
    i_more  = (p_i < last_i);
    is_last = !k_more && !j_more && !i_more;
    calc    = (p_i >= IW'(2)) && (p_i <= last_i) &&
              (p_j >= JW'(1)) && (p_j < last_j) &&
              (p_k >= KW'(1)) && (p_k < last_k);

    pos_i_next = p_i;
    pos_j_next = p_j;
    pos_k_next = p_k;
    if (k_more) begin
      pos_k_next = p_k + KW'(1);
    end else begin
      pos_k_next = '0;
      if (j_more) begin
        pos_j_next = p_j + JW'(1);
      end else begin
        pos_j_next = '0;
        if (i_more) begin
          pos_i_next = p_i + IW'(1);
        end else begin
          pos_i_next = '0;
        end
      end
    end

    // Current cell in this plane; neighbours of the centre in the other plane.
    here_addr = ADDR_W'(ADDR_W'(p_i[0]) * ADDR_W'(PLANE_SIZE) +
                        ADDR_W'(p_j) * ADDR_W'(MAX_CELLS_Z) + ADDR_W'(p_k));
    row_addr  = ADDR_W'(ADDR_W'(~p_i[0]) * ADDR_W'(PLANE_SIZE) +
                        ADDR_W'(p_j) * ADDR_W'(MAX_CELLS_Z) + ADDR_W'(p_k));
    y_hi_addr = row_addr + ADDR_W'(MAX_CELLS_Z);
    y_lo_addr = row_addr - ADDR_W'(MAX_CELLS_Z);
    z_hi_addr = row_addr + ADDR_W'(1);
    z_lo_addr = row_addr - ADDR_W'(1);
  end

  // Position registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      pos_i <= '0;
      pos_j <= '0;
      pos_k <= '0;
    end else if (accept) begin
      pos_i <= pos_i_next;
      pos_j <= pos_j_next;
      pos_k <= pos_k_next;
    end
  end

  // The x store returns the cell two planes back before it is overwritten.
  always_ff @(posedge clk) begin
    if (accept) begin
      x_rd             <= x_mem[here_addr];
      x_mem[here_addr] <= field_x;
    end
  end

  // The y store gives the j neighbours of the centre.
  always_ff @(posedge clk) begin
    if (accept) begin
      y_hi_rd          <= y_mem[y_hi_addr];
      y_lo_rd          <= y_mem[y_lo_addr];
      y_mem[here_addr] <= field_y;
    end
  end

  // The z store gives the k neighbours of the centre.
  always_ff @(posedge clk) begin
    if (accept) begin
      z_hi_rd          <= z_mem[z_hi_addr];
      z_lo_rd          <= z_mem[z_lo_addr];
      z_mem[here_addr] <= field_z;
    end
  end

  // Read stage control and payload.
  always_ff @(posedge clk) begin
    if (rst) begin
      f1_valid <= 1'b0;
    end else begin
      f1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f1_flags.calc  <= calc;
      f1_flags.last  <= is_last;
      f1_flags.clear <= grid_start;
      fx_q           <= field_x;
    end
  end

  // Differences go into the queue from the registered reads of the read stage.
  assign push            = f1_valid;
  assign push_item.flags = f1_flags;
  assign push_item.dx    = DIFF_W'(DIFF_W'(fx_q) - DIFF_W'(x_rd));
  assign push_item.dy    = DIFF_W'(DIFF_W'(y_hi_rd) - DIFF_W'(y_lo_rd));
  assign push_item.dz    = DIFF_W'(DIFF_W'(z_hi_rd) - DIFF_W'(z_lo_rd));

endmodule

`default_nettype wire

// ----- rtl/gdm_queue.sv -----
// Short register queue that decouples the front from the arithmetic back end.
// Depends on gdm_pkg for the entry type and depth.
`default_nettype none

module gdm_queue (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     push,
  input  gdm_pkg::gdm_item_t       push_item,
  input  logic                     pop,
  output gdm_pkg::gdm_item_t       head,
  output logic                     not_empty,
  output logic [gdm_pkg::QC_W-1:0] count
);
  import gdm_pkg::*;

  gdm_item_t       slots [Q_DEPTH];
  logic [QP_W-1:0] wr_ptr, rd_ptr;
  logic            do_pop;

  assign not_empty = (count != '0);
  assign head      = slots[rd_ptr];
  assign do_pop    = pop & not_empty;

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QP_W'(Q_DEPTH - 1)) ? '0 : wr_ptr + QP_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QP_W'(Q_DEPTH - 1)) ? '0 : rd_ptr + QP_W'(1);
      end
      if (push && !do_pop) begin
        count <= count + QC_W'(1);
      end else if (!push && do_pop) begin
        count <= count - QC_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/gdm_back.sv -----
// Back end of the divergence core: weighted sum, rounding, saturation, running
// maximum and the result register. Depends on gdm_pkg; fed by gdm_queue.
`default_nettype none

module gdm_back (
  input  logic                         clk,
  input  logic                         rst,
  input  gdm_pkg::gdm_cfg_t            cfg,
  input  logic                         q_valid,
  input  gdm_pkg::gdm_item_t           q_item,
  output logic                         q_pop,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [gdm_pkg::RES_W-1:0]    out_max,
  output logic                         out_sat
);
  import gdm_pkg::*;

  logic en;

  // Product stage.
  logic                     m_valid;
  gdm_flags_t               m_flags;
  logic signed [PROD_W-1:0] m_xh, m_xl, m_yh, m_yl, m_zh, m_zl;

  // Sum stage.
  logic                    s_valid;
  gdm_flags_t              s_flags;
  logic signed [SUM_W-1:0] s_sa, s_sb;

  // Combined Q.32 total.
  logic                    t_valid;
  gdm_flags_t              t_flags;
  logic signed [TOT_W-1:0] t_tot;

  // Rounded magnitude.
  logic             c_valid;
  gdm_flags_t       c_flags;
  logic [RES_W-1:0] c_mag;
  logic             c_sat;

  // Magnitude logic.
  logic [TOT_W-1:0] t_bits, abs_round;
  logic             t_neg;
  logic [MAG_W-1:0] mag_full;
  logic             mag_over;

  // Accumulator.
  logic [RES_W-1:0] running_max, base_max, upd_max;
  logic             clamp_seen, base_clamp, upd_clamp;

  // The whole pipe holds only while a grid result waits on a full output.
  assign en    = !(c_valid && c_flags.last && out_valid && !out_ready);
  assign q_pop = en & q_valid;

  // Valid bits of the pipe.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
      s_valid <= 1'b0;
      t_valid <= 1'b0;
      c_valid <= 1'b0;
    end else if (en) begin
      m_valid <= q_valid;
      s_valid <= m_valid;
      t_valid <= s_valid;
      c_valid <= t_valid;
    end
  end

  // Each difference times the high and low halves of its spacing.
  always_ff @(posedge clk) begin
    if (en) begin
      m_flags <= q_item.flags;
      m_xh <= PROD_W'($signed(q_item.dx)) *
              PROD_W'($signed({1'b0, cfg.half_inv_spacing_x[H_W-1:H_HALF_W]}));
      m_xl <= PROD_W'($signed(q_item.dx)) *
              PROD_W'($signed({1'b0, cfg.half_inv_spacing_x[H_HALF_W-1:0]}));
      m_yh <= PROD_W'($signed(q_item.dy)) *
              PROD_W'($signed({1'b0, cfg.half_inv_spacing_y[H_W-1:H_HALF_W]}));
      m_yl <= PROD_W'($signed(q_item.dy)) *
              PROD_W'($signed({1'b0, cfg.half_inv_spacing_y[H_HALF_W-1:0]}));
      m_zh <= PROD_W'($signed(q_item.dz)) *
              PROD_W'($signed({1'b0, cfg.half_inv_spacing_z[H_W-1:H_HALF_W]}));
      m_zl <= PROD_W'($signed(q_item.dz)) *
              PROD_W'($signed({1'b0, cfg.half_inv_spacing_z[H_HALF_W-1:0]}));
    end
  end

  // High and low partial sums.
  always_ff @(posedge clk) begin
    if (en) begin
      s_flags <= m_flags;
      s_sa    <= SUM_W'(m_xh) + SUM_W'(m_yh) + SUM_W'(m_zh);
      s_sb    <= SUM_W'(m_xl) + SUM_W'(m_yl) + SUM_W'(m_zl);
    end
  end

  // Full total in Q.32.
  always_ff @(posedge clk) begin
    if (en) begin
      t_flags <= s_flags;
      t_tot   <= (TOT_W'(s_sa) <<< FRAC_BITS) + TOT_W'(s_sb);
    end
  end

  // Magnitude rounded to Q.16 with ties away from zero: |T| = ~T + 1 when negative.
  always_comb begin
    t_bits    = t_tot;
    t_neg     = t_bits[TOT_W-1];
    abs_round = (t_neg ? ~t_bits : t_bits) +
                (t_neg ? TOT_W'((1 << (FRAC_BITS - 1)) + 1) : TOT_W'(1 << (FRAC_BITS - 1)));
    mag_full  = abs_round[TOT_W-1:FRAC_BITS];
    mag_over  = (64'(mag_full) > RESULT_MAX);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_flags <= t_flags;
      c_sat   <= mag_over;
      c_mag   <= mag_over ? RES_W'(RESULT_MAX) : RES_W'(mag_full);
    end
  end

  // Running maximum, cleared at grid start before the cell is folded in.
  always_comb begin
    base_max   = c_flags.clear ? '0 : running_max;
    base_clamp = c_flags.clear ? 1'b0 : clamp_seen;
    upd_max    = (c_flags.calc && (c_mag > base_max)) ? c_mag : base_max;
    upd_clamp  = base_clamp | (c_flags.calc & c_sat);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_max <= '0;
      clamp_seen  <= 1'b0;
    end else if (en && c_valid) begin
      if (c_flags.last) begin
        running_max <= '0;
        clamp_seen  <= 1'b0;
      end else begin
        running_max <= upd_max;
        clamp_seen  <= upd_clamp;
      end
    end
  end

  // Result register; it accepts a new result in the cycle the old one leaves.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en && c_valid && c_flags.last) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en && c_valid && c_flags.last) begin
      out_max <= cfg.magnetic_mode ? upd_max : '0;
      out_sat <= cfg.magnetic_mode & upd_clamp;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/grid_divergence_max_stencil_core.sv -----
// Maximum absolute divergence over a 3-D grid: one cell per cycle in while s_tready is high,
// one beat per grid out. The last cell passes the read stage, queue, product, sum, total
// and magnitude stages before the result register.
// Reset (rst, synchronous): clears positions, maximum, queue, pipe and restores the registers.
// The plane stores are not cleared; every entry is written before a centre reads it.
// Depends on gdm_pkg, gdm_front, gdm_queue and gdm_back.
`default_nettype none

module grid_divergence_max_stencil_core (
  input  logic                             clk,
  input  logic                             rst,
  // Configuration write port.
  input  logic                             cfg_we,
  input  logic [gdm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [gdm_pkg::CFG_W-1:0]        cfg_data,
  // Cell stream.
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [gdm_pkg::S_DATA_W-1:0]     s_tdata,  // field_x, field_y, field_z
  input  logic                             s_tuser,  // grid_start
  // Result stream.
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [gdm_pkg::M_DATA_W-1:0]     m_tdata,  // max_divergence
  output logic                             m_tuser   // saturated
);
  import gdm_pkg::*;

  gdm_cfg_t         cfg;
  logic             push, pop, q_not_empty;
  gdm_item_t        push_item, head;
  logic [QC_W-1:0]  q_count;
  logic [RES_W-1:0] out_max;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.magnetic_mode      <= 1'b1;
      cfg.cells_x            <= CX_W'(64);
      cfg.cells_y            <= CY_W'(64);
      cfg.cells_z            <= CZ_W'(64);
      cfg.half_inv_spacing_x <= H_W'(32768);
      cfg.half_inv_spacing_y <= H_W'(32768);
      cfg.half_inv_spacing_z <= H_W'(32768);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MAGNETIC_MODE: cfg.magnetic_mode      <= cfg_data[0];
        CFG_CELLS_X:       cfg.cells_x            <= cfg_data[CX_W-1:0];
        CFG_CELLS_Y:       cfg.cells_y            <= cfg_data[CY_W-1:0];
        CFG_CELLS_Z:       cfg.cells_z            <= cfg_data[CZ_W-1:0];
        CFG_HALF_INV_X:    cfg.half_inv_spacing_x <= cfg_data[H_W-1:0];
        CFG_HALF_INV_Y:    cfg.half_inv_spacing_y <= cfg_data[H_W-1:0];
        CFG_HALF_INV_Z:    cfg.half_inv_spacing_z <= cfg_data[H_W-1:0];
        default: ;
      endcase
    end
  end

  // Position tracking, classification and plane stores.
  gdm_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .field_x   (s_tdata[FIELD_W-1:0]),
    .field_y   (s_tdata[2*FIELD_W-1:FIELD_W]),
    .field_z   (s_tdata[3*FIELD_W-1:2*FIELD_W]),
    .grid_start(s_tuser),
    .q_count   (q_count),
    .push      (push),
    .push_item (push_item)
  );

  // Decoupling queue.
  gdm_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_item(push_item),
    .pop      (pop),
    .head     (head),
    .not_empty(q_not_empty),
    .count    (q_count)
  );

  // Arithmetic, maximum and result register.
  gdm_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .q_valid  (q_not_empty),
    .q_item   (head),
    .q_pop    (pop),
    .out_valid(m_tvalid),
    .out_ready(m_tready),
    .out_max  (out_max),
    .out_sat  (m_tuser)
  );

  assign m_tdata = M_DATA_W'(out_max);

endmodule

`default_nettype wire

// ----- rtl/gdm_checker.sv -----
// Port-level checks for the divergence maximum core, bound to its top level.
// Depends on gdm_pkg and grid_divergence_max_stencil_core.
`default_nettype none

module gdm_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             cfg_we,
  input logic [gdm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input logic [gdm_pkg::CFG_W-1:0]        cfg_data,
  input logic                             s_tready,
  input logic                             m_tvalid,
  input logic                             m_tready,
  input logic [gdm_pkg::M_DATA_W-1:0]     m_tdata,
  input logic                             m_tuser
);
  import gdm_pkg::*;

  // Shadow of the magnetic mode register as written on the port.
  logic mode_shadow;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_shadow <= 1'b1;
    end else if (cfg_we && (cfg_index == CFG_MAGNETIC_MODE)) begin
      mode_shadow <= cfg_data[0];
    end
  end

  // A held result keeps its beat until it is taken.
  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result beat changed while stalled");

  // Reset empties the pipe and leaves the input open.
  a_reset_state: assert property (@(posedge clk)
    rst |=> !m_tvalid && s_tready)
    else $error("core not idle after reset");

  // With magnetic mode off the result is all zero.
  a_mode_off_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !mode_shadow |-> (m_tdata == '0) && !m_tuser)
    else $error("nonzero result with magnetic mode off");

  // A clamped grid always reports the full-scale maximum.
  a_sat_full_scale: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata[RES_W-1:0] == RES_W'(RESULT_MAX))
    else $error("saturation flag without full-scale maximum");

endmodule

bind grid_divergence_max_stencil_core gdm_checker u_checker (.*);

`default_nettype wire
